### src/kse_pkg.sv
`timescale 1ns / 1ps

package kse_pkg;

  typedef enum logic [1:0] {
    REQ_LOAD  = 2'd0,
    REQ_MEAS  = 2'd1,
    REQ_OUT   = 2'd2,
    REQ_CLEAR = 2'd3
  } req_e;

  localparam logic [2:0] SEL_CD  = 3'd0;
  localparam logic [2:0] SEL_M   = 3'd1;
  localparam logic [2:0] SEL_AD  = 3'd2;
  localparam logic [2:0] SEL_ADM = 3'd3;
  localparam logic [2:0] SEL_FDM = 3'd4;

  localparam logic CFG_ALPHA = 1'b0;
  localparam logic CFG_BETA  = 1'b1;

  // where a finished dot product goes
  typedef enum logic [1:0] {
    DST_VEC = 2'd0,
    DST_F   = 2'd1,
    DST_OUT = 2'd2
  } dst_e;

  // one multiply-accumulate slot travelling down the datapath
  typedef struct packed {
    logic vld;
    logic first;
    logic last;
    logic lift;
    logic neg;
    logic ext;
    logic esel;
    dst_e dst;
  } slot_t;

  // round half up, then saturate Q16.48 down to Q8.24
  function automatic logic signed [31:0] fix_q824(input logic [63:0] acc);
    logic [63:0] u;
    logic [39:0] q;
    u = acc + 64'd8388608;
    q = u[63:24];
    if (!q[39] && (|q[38:31])) begin
      fix_q824 = 32'sh7fffffff;
    end else if (q[39] && !(&q[38:31])) begin
      fix_q824 = 32'sh80000000;
    end else begin
      fix_q824 = $signed(q[31:0]);
    end
  endfunction

endpackage

### src/kse_coef_mem.sv
`timescale 1ns / 1ps

module kse_coef_mem #(
  parameter int DEPTH = 16,
  parameter int AW    = 4
) (
  input  logic                 clk_i,
  input  logic                 we_i,
  input  logic [AW-1:0]        waddr_i,
  input  logic signed [31:0]   wdata_i,
  input  logic [AW-1:0]        raddr_i,
  output logic signed [31:0]   rdata_o
);

  logic signed [31:0] mem [DEPTH];
  logic signed [31:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

### src/kse_vec_mem.sv
`timescale 1ns / 1ps

module kse_vec_mem #(
  parameter int DEPTH = 80,
  parameter int AW    = 7,
  parameter int NV    = 48
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 clr_i,
  input  logic                 we_i,
  input  logic [AW-1:0]        waddr_i,
  input  logic signed [31:0]   wdata_i,
  input  logic [AW-1:0]        raddr_i,
  output logic signed [31:0]   rdata_o
);

  localparam int NVW = $clog2(NV);

  logic signed [31:0] mem [DEPTH];
  logic signed [31:0] rdata_q;
  logic [NV-1:0]      vld_q;
  logic               rvld_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  // state vectors read as zero until written after reset or a clear
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q  <= '0;
      rvld_q <= 1'b0;
    end else begin
      if (clr_i) begin
        vld_q <= '0;
      end else if (we_i && (32'(waddr_i) < NV)) begin
        vld_q[waddr_i[NVW-1:0]] <= 1'b1;
      end
      rvld_q <= (32'(raddr_i) >= NV) || vld_q[raddr_i[NVW-1:0]];
    end
  end

  assign rdata_o = rvld_q ? rdata_q : 32'sd0;

endmodule

### src/kse_mac.sv
`timescale 1ns / 1ps

module kse_mac
  import kse_pkg::*;
#(
  parameter int VAW = 7
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  kse_pkg::slot_t       slot_i,
  input  logic [VAW-1:0]       dst_i,
  input  logic signed [31:0]   coef_i,
  input  logic signed [31:0]   vec_i,
  input  logic signed [31:0]   alpha_i,
  input  logic signed [31:0]   beta_i,
  input  logic signed [31:0]   prev_i,
  input  logic [5:0]           row_i,
  input  logic                 last_row_i,
  output logic                 wb_we_o,
  output logic [VAW-1:0]       wb_addr_o,
  output logic signed [31:0]   wb_data_o,
  output logic                 out_valid_o,
  output logic signed [31:0]   out_value_o,
  output logic [5:0]           out_index_o,
  output logic                 out_last_o
);

  slot_t              s1_q, s2_q, s3_q;
  logic [VAW-1:0]     d1_q, d2_q, d3_q;
  logic signed [31:0] a, b;
  logic [63:0]        prod_d, prod_q;
  logic [63:0]        acc_d, acc_q;
  logic [63:0]        acc_base;
  logic signed [31:0] res;
  logic signed [31:0] f_q;
  logic               done;
  logic               out_valid_q;
  logic signed [31:0] out_value_q;
  logic [5:0]         out_index_q;
  logic               out_last_q;

  // memory data arrives with s1; the final mix takes gains and registers instead
  always_comb begin
    a = s1_q.ext ? (s1_q.esel ? beta_i : alpha_i) : coef_i;
    b = s1_q.ext ? (s1_q.esel ? f_q : prev_i) : vec_i;
    if (s1_q.lift) begin
      prod_d = {{8{b[31]}}, b, 24'd0};
    end else begin
      prod_d = 64'(a * b);
    end
  end

  always_comb begin
    acc_base = s2_q.first ? 64'd0 : acc_q;
    if (s2_q.neg && !s2_q.lift) begin
      acc_d = acc_base - prod_q;
    end else begin
      acc_d = acc_base + prod_q;
    end
  end

  assign res  = fix_q824(acc_q);
  assign done = s3_q.vld && s3_q.last;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_q        <= '0;
      s2_q        <= '0;
      s3_q        <= '0;
      out_valid_q <= 1'b0;
    end else begin
      s1_q        <= slot_i;
      s2_q        <= s1_q;
      s3_q        <= s2_q;
      out_valid_q <= done && (s3_q.dst == DST_OUT);
    end
  end

  always_ff @(posedge clk_i) begin
    d1_q   <= dst_i;
    d2_q   <= d1_q;
    d3_q   <= d2_q;
    prod_q <= prod_d;
    if (s2_q.vld) begin
      acc_q <= acc_d;
    end
    if (done && (s3_q.dst == DST_F)) begin
      f_q <= res;
    end
    if (done && (s3_q.dst == DST_OUT)) begin
      out_value_q <= res;
      out_index_q <= row_i;
      out_last_q  <= last_row_i;
    end
  end

  assign wb_we_o     = done && (s3_q.dst == DST_VEC);
  assign wb_addr_o   = d3_q;
  assign wb_data_o   = res;
  assign out_valid_o = out_valid_q;
  assign out_value_o = out_value_q;
  assign out_index_o = out_index_q;
  assign out_last_o  = out_last_q;

endmodule

### src/kalman_state_estimator_step.sv
// Steady-state Kalman estimator step, Q8.24 fixed point.
// Command channel: an item is taken when start_i is high and busy_o is low.
// Loads write one coefficient, measurement items fill the buffer and a clear
// zeroes the state vectors. The measurement item marked last, with a set index
// below NSETS, starts the update, which runs on one multiply-accumulate unit
// fed by the coefficient and vector memories, one product per cycle within a
// pass; the unit is idle while a pass drains its last write-back.
// An output request for a row below NOUT is answered; for row 0 it first
// advances the step vector. The result shows for one cycle with out_valid_o
// high; the receiver cannot stall, and busy_o is already low in that cycle.
// Configuration writes (cfg_we_i) take effect at once and belong to idle time.
// Reset zeroes the state vectors through valid bits, sets the gains to +1.0
// and -1.0; the coefficient memories hold no reset value.
`timescale 1ns / 1ps

module kalman_state_estimator_step #(
  parameter int NSTATE = 16,
  parameter int NMEAS  = 16,
  parameter int NOUT   = 16,
  parameter int NSETS  = 3
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  output logic               busy_o,
  input  logic [1:0]         req_type_i,
  input  logic [2:0]         matrix_sel_i,
  input  logic [2:0]         set_index_i,
  input  logic [5:0]         row_index_i,
  input  logic [5:0]         col_index_i,
  input  logic signed [31:0] value_in_i,
  input  logic               is_last_i,
  input  logic               cfg_we_i,
  input  logic               cfg_index_i,
  input  logic [31:0]        cfg_wdata_i,
  output logic               out_valid_o,
  output logic signed [31:0] out_value_o,
  output logic [5:0]         out_index_o,
  output logic               out_last_o
);

  import kse_pkg::*;

  localparam int CDSET    = NMEAS * NSTATE;
  localparam int CD_BASE  = 0;
  localparam int M_BASE   = NSETS * CDSET;
  localparam int AD_BASE  = 2 * NSETS * CDSET;
  localparam int ADM_BASE = AD_BASE + NSTATE * NSTATE;
  localparam int FDM_BASE = ADM_BASE + NSTATE * NSTATE;
  localparam int CDEPTH   = FDM_BASE + NOUT * NSTATE;
  localparam int CAW      = $clog2(CDEPTH);

  localparam int XS_BASE  = 0;
  localparam int XP_BASE  = NSTATE;
  localparam int XU_BASE  = 2 * NSTATE;
  localparam int MB_BASE  = 3 * NSTATE;
  localparam int IN_BASE  = 3 * NSTATE + NMEAS;
  localparam int VDEPTH   = 3 * NSTATE + 2 * NMEAS;
  localparam int VAW      = $clog2(VDEPTH);

  localparam logic [6:0] NS7 = 7'(NSTATE);
  localparam logic [6:0] NM7 = 7'(NMEAS);

  typedef enum logic [9:0] {
    ST_IDLE  = 10'b0000000001,
    ST_INNOV = 10'b0000000010,
    ST_UPD   = 10'b0000000100,
    ST_PROP  = 10'b0000001000,
    ST_STEP  = 10'b0000010000,
    ST_COPY  = 10'b0000100000,
    ST_ADV   = 10'b0001000000,
    ST_FOUT  = 10'b0010000000,
    ST_MIX   = 10'b0100000000,
    ST_DRAIN = 10'b1000000000
  } state_e;

  state_e             state_q, state_d, nxt_q, nxt_d, tgt, jnext;
  logic [1:0]         drn_q, drn_d;
  logic [6:0]         rcnt_q, rcnt_d, ccnt_q, ccnt_d;
  logic               lpend_q, lpend_d;
  logic [CAW-1:0]     caddr_q, caddr_d, cbase;
  logic [2:0]         set_q, set_d, cset;
  logic [5:0]         row_q, row_d, crow;
  logic signed [31:0] prev_q, prev_d;
  logic signed [31:0] alpha_q, beta_q;
  logic               enter;

  // job description of the running pass
  logic [6:0]         jnrows, jncols;
  logic [VAW-1:0]     jvbase, jlbase, jdbase;
  logic               jlift, jneg, jext;
  dst_e               jdst;

  slot_t              slot;
  logic [VAW-1:0]     vraddr;

  logic               ld_ok, ld_we;
  logic [CAW-1:0]     ld_addr;
  logic               mw_we, clr;

  logic               wb_we;
  logic [VAW-1:0]     wb_addr;
  logic signed [31:0] wb_data;
  logic               vm_we;
  logic [VAW-1:0]     vm_waddr;
  logic signed [31:0] vm_wdata;
  logic signed [31:0] coef_rd, vec_rd;

  // coefficient address of a load
  always_comb begin
    ld_ok   = 1'b0;
    ld_addr = '0;
    case (matrix_sel_i)
      SEL_CD: begin
        ld_ok   = (32'(set_index_i) < NSETS) && (32'(row_index_i) < NMEAS)
                  && (32'(col_index_i) < NSTATE);
        ld_addr = CAW'(CD_BASE) + CAW'(set_index_i) * CAW'(CDSET)
                  + CAW'(row_index_i) * CAW'(NSTATE) + CAW'(col_index_i);
      end
      SEL_M: begin
        ld_ok   = (32'(set_index_i) < NSETS) && (32'(row_index_i) < NSTATE)
                  && (32'(col_index_i) < NMEAS);
        ld_addr = CAW'(M_BASE) + CAW'(set_index_i) * CAW'(CDSET)
                  + CAW'(row_index_i) * CAW'(NMEAS) + CAW'(col_index_i);
      end
      SEL_AD: begin
        ld_ok   = (32'(row_index_i) < NSTATE) && (32'(col_index_i) < NSTATE);
        ld_addr = CAW'(AD_BASE) + CAW'(row_index_i) * CAW'(NSTATE) + CAW'(col_index_i);
      end
      SEL_ADM: begin
        ld_ok   = (32'(row_index_i) < NSTATE) && (32'(col_index_i) < NSTATE);
        ld_addr = CAW'(ADM_BASE) + CAW'(row_index_i) * CAW'(NSTATE) + CAW'(col_index_i);
      end
      SEL_FDM: begin
        ld_ok   = (32'(row_index_i) < NOUT) && (32'(col_index_i) < NSTATE);
        ld_addr = CAW'(FDM_BASE) + CAW'(row_index_i) * CAW'(NSTATE) + CAW'(col_index_i);
      end
      default: begin
        ld_ok   = 1'b0;
        ld_addr = '0;
      end
    endcase
  end

  always_comb begin
    jnrows = NS7;
    jncols = NS7;
    jvbase = VAW'(XU_BASE);
    jlbase = VAW'(XS_BASE);
    jdbase = VAW'(XS_BASE);
    jlift  = 1'b0;
    jneg   = 1'b0;
    jext   = 1'b0;
    jdst   = DST_VEC;
    jnext  = ST_IDLE;
    case (state_q)
      ST_INNOV: begin
        jnrows = NM7;
        jvbase = VAW'(XS_BASE);
        jlbase = VAW'(MB_BASE);
        jdbase = VAW'(IN_BASE);
        jlift  = 1'b1;
        jneg   = 1'b1;
        jnext  = ST_UPD;
      end
      ST_UPD: begin
        jncols = NM7;
        jvbase = VAW'(IN_BASE);
        jlbase = VAW'(XS_BASE);
        jdbase = VAW'(XU_BASE);
        jlift  = 1'b1;
        jnext  = ST_PROP;
      end
      ST_PROP: begin
        jdbase = VAW'(XS_BASE);
        jnext  = ST_STEP;
      end
      ST_STEP: begin
        jdbase = VAW'(XP_BASE);
      end
      ST_COPY: begin
        jncols = 7'd0;
        jlbase = VAW'(XP_BASE);
        jdbase = VAW'(XU_BASE);
        jlift  = 1'b1;
        jnext  = ST_ADV;
      end
      ST_ADV: begin
        jdbase = VAW'(XP_BASE);
        jnext  = ST_FOUT;
      end
      ST_FOUT: begin
        jnrows = 7'd1;
        jvbase = VAW'(XP_BASE);
        jdst   = DST_F;
        jnext  = ST_MIX;
      end
      ST_MIX: begin
        jnrows = 7'd1;
        jncols = 7'd2;
        jext   = 1'b1;
        jdst   = DST_OUT;
      end
      default: begin
        jnrows = NS7;
      end
    endcase
  end

  // first coefficient address of the pass being entered
  assign cset = (state_q == ST_IDLE) ? set_index_i : set_q;
  assign crow = (state_q == ST_IDLE) ? row_index_i : row_q;

  always_comb begin
    case (tgt)
      ST_INNOV: cbase = CAW'(CD_BASE) + CAW'(cset) * CAW'(CDSET);
      ST_UPD:   cbase = CAW'(M_BASE) + CAW'(cset) * CAW'(CDSET);
      ST_PROP:  cbase = CAW'(AD_BASE);
      ST_STEP:  cbase = CAW'(ADM_BASE);
      ST_ADV:   cbase = CAW'(ADM_BASE);
      ST_FOUT:  cbase = CAW'(FDM_BASE) + CAW'(crow) * CAW'(NSTATE);
      default:  cbase = '0;
    endcase
  end

  always_comb begin
    state_d = state_q;
    nxt_d   = nxt_q;
    drn_d   = drn_q;
    rcnt_d  = rcnt_q;
    ccnt_d  = ccnt_q;
    lpend_d = lpend_q;
    caddr_d = caddr_q;
    set_d   = set_q;
    row_d   = row_q;
    prev_d  = prev_q;
    enter   = 1'b0;
    tgt     = ST_IDLE;
    slot    = '0;
    vraddr  = '0;
    ld_we   = 1'b0;
    mw_we   = 1'b0;
    clr     = 1'b0;
    case (state_q)
      ST_IDLE: begin
        if (start_i) begin
          set_d  = set_index_i;
          row_d  = row_index_i;
          prev_d = value_in_i;
          unique case (req_e'(req_type_i))
            REQ_LOAD: ld_we = ld_ok;
            REQ_MEAS: begin
              mw_we = 32'(row_index_i) < NMEAS;
              if (is_last_i && (32'(set_index_i) < NSETS)) begin
                enter = 1'b1;
                tgt   = ST_INNOV;
              end
            end
            REQ_OUT: begin
              if (32'(row_index_i) < NOUT) begin
                enter = 1'b1;
                tgt   = (row_index_i == 6'd0) ? ST_COPY : ST_FOUT;
              end
            end
            REQ_CLEAR: clr = 1'b1;
          endcase
        end
      end
      ST_DRAIN: begin
        // let the last write-back land before the next pass reads it
        if (drn_q == 2'd2) begin
          if (nxt_q == ST_IDLE) begin
            state_d = ST_IDLE;
          end else begin
            enter = 1'b1;
            tgt   = nxt_q;
          end
        end else begin
          drn_d = drn_q + 2'd1;
        end
      end
      default: begin
        slot.vld  = 1'b1;
        slot.neg  = jneg;
        slot.ext  = jext;
        slot.dst  = jdst;
        slot.esel = ccnt_q[0];
        if (jlift && lpend_q) begin
          slot.lift  = 1'b1;
          slot.first = 1'b1;
          slot.last  = (jncols == 7'd0);
          vraddr     = jlbase + VAW'(rcnt_q);
          lpend_d    = 1'b0;
        end else begin
          slot.first = !jlift && (ccnt_q == 7'd0);
          slot.last  = (ccnt_q == jncols - 7'd1);
          vraddr     = jvbase + VAW'(ccnt_q);
          caddr_d    = caddr_q + CAW'(1);
          ccnt_d     = ccnt_q + 7'd1;
        end
        if (slot.last) begin
          ccnt_d  = 7'd0;
          lpend_d = 1'b1;
          rcnt_d  = rcnt_q + 7'd1;
          if (rcnt_q == jnrows - 7'd1) begin
            state_d = ST_DRAIN;
            nxt_d   = jnext;
            drn_d   = 2'd0;
          end
        end
      end
    endcase
    if (enter) begin
      state_d = tgt;
      rcnt_d  = 7'd0;
      ccnt_d  = 7'd0;
      lpend_d = 1'b1;
      caddr_d = cbase;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      nxt_q   <= ST_IDLE;
      drn_q   <= 2'd0;
      rcnt_q  <= 7'd0;
      ccnt_q  <= 7'd0;
      lpend_q <= 1'b0;
      alpha_q <= 32'sd16777216;
      beta_q  <= -32'sd16777216;
    end else begin
      state_q <= state_d;
      nxt_q   <= nxt_d;
      drn_q   <= drn_d;
      rcnt_q  <= rcnt_d;
      ccnt_q  <= ccnt_d;
      lpend_q <= lpend_d;
      if (cfg_we_i) begin
        unique case (cfg_index_i)
          CFG_ALPHA: alpha_q <= $signed(cfg_wdata_i);
          CFG_BETA:  beta_q  <= $signed(cfg_wdata_i);
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    caddr_q <= caddr_d;
    set_q   <= set_d;
    row_q   <= row_d;
    prev_q  <= prev_d;
  end

  // write-backs only happen while busy, measurement writes only while idle
  assign vm_we    = wb_we || mw_we;
  assign vm_waddr = wb_we ? wb_addr : VAW'(MB_BASE) + VAW'(row_index_i);
  assign vm_wdata = wb_we ? wb_data : value_in_i;

  kse_coef_mem #(
    .DEPTH(CDEPTH),
    .AW   (CAW)
  ) u_coef_mem (
    .clk_i  (clk_i),
    .we_i   (ld_we),
    .waddr_i(ld_addr),
    .wdata_i(value_in_i),
    .raddr_i(caddr_q),
    .rdata_o(coef_rd)
  );

  kse_vec_mem #(
    .DEPTH(VDEPTH),
    .AW   (VAW),
    .NV   (3 * NSTATE)
  ) u_vec_mem (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .clr_i  (clr),
    .we_i   (vm_we),
    .waddr_i(vm_waddr),
    .wdata_i(vm_wdata),
    .raddr_i(vraddr),
    .rdata_o(vec_rd)
  );

  kse_mac #(
    .VAW(VAW)
  ) u_mac (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .slot_i     (slot),
    .dst_i      (jdbase + VAW'(rcnt_q)),
    .coef_i     (coef_rd),
    .vec_i      (vec_rd),
    .alpha_i    (alpha_q),
    .beta_i     (beta_q),
    .prev_i     (prev_q),
    .row_i      (row_q),
    .last_row_i (32'(row_q) == NOUT - 1),
    .wb_we_o    (wb_we),
    .wb_addr_o  (wb_addr),
    .wb_data_o  (wb_data),
    .out_valid_o(out_valid_o),
    .out_value_o(out_value_o),
    .out_index_o(out_index_o),
    .out_last_o (out_last_o)
  );

  assign busy_o = (state_q != ST_IDLE);

endmodule

### src/kse_checker.sv
`timescale 1ns / 1ps

module kse_checker #(
  parameter int NOUT = 16
) (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        start_i,
  input logic        busy_o,
  input logic [1:0]  req_type_i,
  input logic        out_valid_o,
  input logic [5:0]  out_index_o,
  input logic        out_last_o
);

  import kse_pkg::*;

  // a result only ends a run of busy cycles
  a_out_after_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> $past(busy_o))
    else $error("result without preceding work");

  a_out_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |=> !out_valid_o)
    else $error("result strobe longer than one cycle");

  a_out_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (32'(out_index_o) < NOUT)
                    && (out_last_o == (32'(out_index_o) == NOUT - 1)))
    else $error("bad result index or last flag");

  a_short_cmd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o && ((req_type_i == REQ_LOAD) || (req_type_i == REQ_CLEAR)))
    |=> !busy_o)
    else $error("load or clear kept the block busy");

endmodule

bind kalman_state_estimator_step kse_checker #(.NOUT(NOUT)) u_kse_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .start_i    (start_i),
  .busy_o     (busy_o),
  .req_type_i (req_type_i),
  .out_valid_o(out_valid_o),
  .out_index_o(out_index_o),
  .out_last_o (out_last_o)
);

### tb/kalman_state_estimator_step_test.sv
`timescale 1ns / 1ps

module kalman_state_estimator_step_test;
  import kse_pkg::*;

  localparam int NST  = 16;
  localparam int NMS  = 16;
  localparam int NOT  = 16;
  localparam int NSET = 3;
  localparam logic signed [31:0] Q_MAX = 32'sh7fffffff;
  localparam logic signed [31:0] Q_MIN = 32'sh80000000;
  localparam logic signed [31:0] Q_ONE = 32'sh01000000;

  typedef logic signed [31:0] vec_t[NST];
  typedef logic signed [31:0] sq_t[NST*NST];

  typedef struct {
    req_e               kind;
    logic [2:0]         sel;
    logic [2:0]         set;
    logic [5:0]         row;
    logic [5:0]         col;
    logic signed [31:0] val;
    logic               last;
    logic               has_exp;
    logic signed [31:0] exp_val;
  } cmd_t;

  typedef struct {
    logic signed [31:0] value;
    logic [5:0]         index;
    logic               last;
  } est_out_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic start_i = 1'b0;
  logic busy_o;
  logic [1:0] req_type_i = '0;
  logic [2:0] matrix_sel_i = '0;
  logic [2:0] set_index_i = '0;
  logic [5:0] row_index_i = '0;
  logic [5:0] col_index_i = '0;
  logic signed [31:0] value_in_i = '0;
  logic is_last_i = 1'b0;
  logic cfg_we_i = 1'b0;
  logic cfg_index_i = 1'b0;
  logic [31:0] cfg_wdata_i = '0;
  logic out_valid_o;
  logic signed [31:0] out_value_o;
  logic [5:0] out_index_o;
  logic out_last_o;

  kalman_state_estimator_step uut (
    .clk_i, .rst_ni, .start_i, .busy_o, .req_type_i, .matrix_sel_i, .set_index_i,
    .row_index_i, .col_index_i, .value_in_i, .is_last_i, .cfg_we_i, .cfg_index_i,
    .cfg_wdata_i, .out_valid_o, .out_value_o, .out_index_o, .out_last_o
  );

  initial begin
    forever #6 clk_i = ~clk_i;
  end

  // estimator mirror
  logic signed [31:0] alpha_q, beta_q;
  logic signed [31:0] cd_mem[NSET*NMS*NST];
  logic signed [31:0] gain_mem[NSET*NST*NMS];
  sq_t ad_mem, adm_mem, fdm_mem;
  vec_t xhat, xstep, xupd;
  logic signed [31:0] meas_mem[NMS];

  est_out_t pending_q[$];
  int errors = 0;
  int idle_pct = 0;

  function automatic logic [63:0] qmul(logic signed [31:0] a, logic signed [31:0] b);
    logic signed [63:0] x, y;
    x = a;
    y = b;
    return x * y;
  endfunction

  function automatic logic signed [31:0] round_sat(logic [63:0] acc);
    logic signed [63:0] q;
    q = $signed(acc + 64'd8388608) >>> 24;
    if (q > 64'sh7fffffff) return Q_MAX;
    if (q < -64'sh80000000) return Q_MIN;
    return q[31:0];
  endfunction

  function automatic vec_t mat_times(sq_t m, vec_t v);
    vec_t r;
    logic [63:0] acc;
    for (int i = 0; i < NST; i++) begin
      acc = '0;
      for (int j = 0; j < NST; j++) acc += qmul(m[i*NST+j], v[j]);
      r[i] = round_sat(acc);
    end
    return r;
  endfunction

  task automatic estimate_update(input int s);
    logic signed [31:0] innov[NMS];
    logic [63:0] acc;
    for (int i = 0; i < NMS; i++) begin
      acc = {{8{meas_mem[i][31]}}, meas_mem[i], 24'd0};
      for (int j = 0; j < NST; j++) acc -= qmul(cd_mem[(s*NMS+i)*NST+j], xhat[j]);
      innov[i] = round_sat(acc);
    end
    for (int i = 0; i < NST; i++) begin
      acc = {{8{xhat[i][31]}}, xhat[i], 24'd0};
      for (int k = 0; k < NMS; k++) acc += qmul(gain_mem[(s*NST+i)*NMS+k], innov[k]);
      xupd[i] = round_sat(acc);
    end
    xhat = mat_times(ad_mem, xupd);
    xstep = mat_times(adm_mem, xupd);
  endtask

  task automatic estimate_item(input cmd_t c, output bit got, output est_out_t r);
    logic [63:0] acc;
    logic signed [31:0] f;
    got = 1'b0;
    r = '{default: '0};
    case (c.kind)
      REQ_LOAD: begin
        case (c.sel)
          SEL_CD:  if (c.set < NSET && c.row < NMS && c.col < NST)
                     cd_mem[(c.set*NMS+c.row)*NST+c.col] = c.val;
          SEL_M:   if (c.set < NSET && c.row < NST && c.col < NMS)
                     gain_mem[(c.set*NST+c.row)*NMS+c.col] = c.val;
          SEL_AD:  if (c.row < NST && c.col < NST) ad_mem[c.row*NST+c.col] = c.val;
          SEL_ADM: if (c.row < NST && c.col < NST) adm_mem[c.row*NST+c.col] = c.val;
          SEL_FDM: if (c.row < NOT && c.col < NST) fdm_mem[c.row*NST+c.col] = c.val;
          default: ;
        endcase
      end
      REQ_MEAS: begin
        if (c.row < NMS) meas_mem[c.row] = c.val;
        if (c.last && c.set < NSET) estimate_update(c.set);
      end
      REQ_CLEAR: begin
        xhat = '{default: '0};
        xstep = '{default: '0};
        xupd = '{default: '0};
      end
      default: begin
        if (c.row < NOT) begin
          if (c.row == 0) begin
            xupd = xstep;
            xstep = mat_times(adm_mem, xupd);
          end
          acc = '0;
          for (int j = 0; j < NST; j++) acc += qmul(fdm_mem[c.row*NST+j], xstep[j]);
          f = round_sat(acc);
          r.value = round_sat(qmul(alpha_q, c.val) + qmul(beta_q, f));
          r.index = c.row;
          r.last = (c.row == NOT - 1);
          got = 1'b1;
        end
      end
    endcase
  endtask

  task automatic send_cmd(input cmd_t c);
    bit got;
    est_out_t r;
    if (idle_pct > 0 && $urandom_range(99) < idle_pct) begin
      start_i <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk_i);
    end
    start_i <= 1'b1;
    req_type_i <= c.kind;
    matrix_sel_i <= c.sel;
    set_index_i <= c.set;
    row_index_i <= c.row;
    col_index_i <= c.col;
    value_in_i <= c.val;
    is_last_i <= c.last;
    do @(posedge clk_i); while (busy_o);
    estimate_item(c, got, r);
    if (got) begin
      if (c.has_exp) r.value = c.exp_val;
      pending_q.push_back(r);
    end
  endtask

  function automatic cmd_t mk(req_e k, logic [2:0] sel, logic [2:0] set, logic [5:0] row,
                              logic [5:0] col, logic signed [31:0] v, logic last);
    cmd_t c;
    c = '{kind: k, sel: sel, set: set, row: row, col: col, val: v, last: last,
          has_exp: 1'b0, exp_val: '0};
    return c;
  endfunction

  function automatic logic signed [31:0] rand_q();
    case ($urandom_range(9))
      0: return Q_MAX;
      1: return Q_MIN;
      2, 3: return $urandom;
      default: return $signed($urandom_range(0, 32'h7fffff)) - 32'sh400000;
    endcase
  endfunction

  function automatic logic signed [31:0] small_q();
    return $signed($urandom_range(0, 32'h7fffff)) - 32'sh400000;
  endfunction

  // hold the sender until every result is back and the block is quiet
  task automatic drain(input int tail);
    start_i <= 1'b0;
    @(posedge clk_i);
    while (pending_q.size() != 0 || busy_o) @(posedge clk_i);
    repeat (tail) @(posedge clk_i);
  endtask

  task automatic write_gain(input logic idx, input logic [31:0] data);
    cfg_we_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_wdata_i <= data;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == CFG_ALPHA) alpha_q = data;
    else beta_q = data;
    @(posedge clk_i);
  endtask

  task automatic run_random(input int n_items);
    int sent;
    int s, r0, r1;
    sent = 0;
    while (sent < n_items) begin
      case ($urandom_range(19))
        0, 1, 2, 3, 4, 5, 6: begin
          s = ($urandom_range(9) == 0) ? $urandom_range(3, 7) : $urandom_range(NSET - 1);
          for (int r = 0; r < NMS; r++) begin
            send_cmd(mk(REQ_MEAS, $urandom, s, r, $urandom, rand_q(), r == NMS - 1));
            sent++;
          end
        end
        7, 8, 9, 10, 11, 12: begin
          r0 = 0;
          r1 = NOT - 1;
          if ($urandom_range(9) == 0) begin
            r0 = $urandom_range(NOT - 1);
            r1 = $urandom_range(r0, 63);
          end
          for (int r = r0; r <= r1; r++) begin
            send_cmd(mk(REQ_OUT, $urandom, $urandom, r, $urandom, rand_q(), $urandom));
            sent++;
          end
        end
        13, 14, 15, 16: begin
          repeat (8) begin
            send_cmd(mk(REQ_LOAD, $urandom_range(4), $urandom_range(NSET - 1),
                        $urandom_range(15), $urandom_range(15),
                        ($urandom_range(7) == 0) ? rand_q() : small_q(), $urandom));
            sent++;
          end
        end
        17: begin
          send_cmd(mk(REQ_CLEAR, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom));
          sent++;
        end
        default: begin
          // fully random fields: every store is written by now
          repeat (4) begin
            send_cmd(mk(req_e'($urandom_range(3)), $urandom, $urandom, $urandom, $urandom,
                        $urandom, $urandom));
            sent++;
          end
        end
      endcase
      if ($urandom_range(29) == 0) drain(0);
    end
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o) begin
      if (pending_q.size() == 0) begin
        $display("%0t: unexpected result value %h index %0d", $time, out_value_o, out_index_o);
        errors++;
      end else begin
        est_out_t e;
        e = pending_q.pop_front();
        if (out_value_o !== e.value) begin
          $display("%0t: out_value expected %h actual %h", $time, e.value, out_value_o);
          errors++;
        end
        if (out_index_o !== e.index) begin
          $display("%0t: out_index expected %0d actual %0d", $time, e.index, out_index_o);
          errors++;
        end
        if (out_last_o !== e.last) begin
          $display("%0t: out_last expected %b actual %b", $time, e.last, out_last_o);
          errors++;
        end
      end
    end
  end

  initial begin
    #40ms;
    $display("kalman_state_estimator_step test failed");
    $finish;
  end

  cmd_t plan[$];

  initial begin
    cmd_t c;
    alpha_q = Q_ONE;
    beta_q = -Q_ONE;
    xhat = '{default: '0};
    xstep = '{default: '0};
    xupd = '{default: '0};
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // fill every coefficient and the measurement buffer before anything reads them
    for (int s = 0; s < NSET; s++)
      for (int i = 0; i < 16; i++)
        for (int j = 0; j < 16; j++) begin
          send_cmd(mk(REQ_LOAD, SEL_CD, s, i, j, small_q(), 1'b0));
          send_cmd(mk(REQ_LOAD, SEL_M, s, i, j, small_q(), 1'b0));
        end
    for (int i = 0; i < 16; i++)
      for (int j = 0; j < 16; j++) begin
        send_cmd(mk(REQ_LOAD, SEL_AD, 0, i, j, small_q(), 1'b0));
        send_cmd(mk(REQ_LOAD, SEL_ADM, 0, i, j, small_q(), 1'b0));
        send_cmd(mk(REQ_LOAD, SEL_FDM, 0, i, j, small_q(), 1'b0));
      end
    for (int i = 0; i < NMS; i++) send_cmd(mk(REQ_MEAS, 0, 0, i, 0, small_q(), 1'b0));

    // state is zero here, so with unit gains an answer echoes the previous value
    c = mk(REQ_OUT, 0, 0, 1, 0, Q_MAX, 0);      c.has_exp = 1; c.exp_val = Q_MAX;
    plan.push_back(c);
    c = mk(REQ_OUT, 0, 0, 15, 0, Q_MIN, 0);     c.has_exp = 1; c.exp_val = Q_MIN;
    plan.push_back(c);
    c = mk(REQ_OUT, 0, 0, 0, 0, 0, 0);          c.has_exp = 1; c.exp_val = 0;
    plan.push_back(c);
    plan.push_back(mk(REQ_OUT, 7, 7, 16, 63, 32'sh12345678, 1));
    plan.push_back(mk(REQ_OUT, 0, 0, 63, 0, -1, 0));
    plan.push_back(mk(REQ_LOAD, 5, 0, 0, 0, Q_MAX, 0));
    plan.push_back(mk(REQ_LOAD, 7, 0, 0, 0, Q_MIN, 0));
    plan.push_back(mk(REQ_LOAD, SEL_CD, 3, 0, 0, Q_MAX, 0));
    plan.push_back(mk(REQ_LOAD, SEL_M, 7, 63, 63, Q_MIN, 0));
    plan.push_back(mk(REQ_LOAD, SEL_AD, 0, 16, 0, Q_MAX, 0));
    plan.push_back(mk(REQ_LOAD, SEL_FDM, 0, 0, 63, Q_MIN, 0));
    plan.push_back(mk(REQ_MEAS, 0, 0, 20, 0, Q_MAX, 0));
    plan.push_back(mk(REQ_MEAS, 0, 5, 0, 0, Q_ONE, 1));
    plan.push_back(mk(REQ_MEAS, 0, 0, 15, 0, -Q_ONE, 1));
    plan.push_back(mk(REQ_OUT, 0, 0, 0, 0, Q_ONE, 0));
    plan.push_back(mk(REQ_OUT, 0, 0, 15, 0, -Q_ONE, 0));
    plan.push_back(mk(REQ_MEAS, 0, 2, 63, 0, 0, 1));
    plan.push_back(mk(REQ_OUT, 0, 0, 3, 0, Q_MAX, 0));
    plan.push_back(mk(REQ_CLEAR, 0, 0, 0, 0, 0, 0));
    c = mk(REQ_OUT, 0, 0, 7, 0, Q_ONE, 0);      c.has_exp = 1; c.exp_val = Q_ONE;
    plan.push_back(c);
    plan.push_back(mk(REQ_LOAD, SEL_FDM, 0, 15, 15, Q_MAX, 0));
    plan.push_back(mk(REQ_LOAD, SEL_M, 2, 15, 15, Q_MIN, 0));
    plan.push_back(mk(REQ_MEAS, 0, 1, 1, 0, Q_MIN, 1));
    plan.push_back(mk(REQ_OUT, 0, 0, 0, 0, Q_MIN, 0));
    foreach (plan[i]) send_cmd(plan[i]);
    drain(900);

    write_gain(CFG_ALPHA, 32'h7fffffff);
    write_gain(CFG_BETA, 32'h80000000);
    idle_pct = 27;
    run_random(250);
    drain(900);

    write_gain(CFG_ALPHA, 32'h80000000);
    write_gain(CFG_BETA, 32'h7fffffff);
    idle_pct = 48;
    run_random(250);
    drain(900);

    write_gain(CFG_ALPHA, 32'h00800000);
    write_gain(CFG_BETA, $urandom_range(0, 32'h03ffffff) - 32'h02000000);
    idle_pct = 0;
    run_random(250);
    drain(900);

    if (errors == 0) begin
      $display("kalman_state_estimator_step test passed");
    end else begin
      $display("kalman_state_estimator_step test failed");
    end
    $finish;
  end

endmodule
